@@ hdl/alac_pkg.sv @@
// Shared types, constants and helpers for the analog limit alarm checker.
`default_nettype none

package alac_pkg;

   localparam int NUM_POINTS = 1024;
   localparam int PT_AW      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
   localparam int IDX_W      = 10;
   localparam int IDX_EXT_W  = 17;

   typedef enum logic [2:0] {
      LVL_NORMAL = 3'd0,
      LVL_HIGH   = 3'd1,
      LVL_LOW    = 3'd2,
      LVL_HIHI   = 3'd3,
      LVL_LOLO   = 3'd4
   } alarm_level_type;

   typedef struct packed {
      alarm_level_type level;
      logic            reported;
      logic [31:0]     start_time;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] point_index;
      logic [31:0]      sample_value;
      logic [31:0]      previous_value;
      logic [31:0]      low_limit;
      logic [31:0]      high_limit;
      logic [31:0]      lowlow_limit;
      logic [31:0]      highhigh_limit;
      logic [15:0]      delay_seconds;
      logic             alarm_enabled;
      logic [31:0]      now_seconds;
   } req_word_type;

   typedef struct packed {
      entry_type       entry_next;
      logic            fire;
      alarm_level_type level;
   } eval_out_type;

   typedef struct packed {
      logic [IDX_W-1:0] event_point;
      logic [2:0]       event_level;
      logic             is_return;
      logic             escalated;
      logic [31:0]      event_value;
      logic [31:0]      event_previous;
   } rsp_word_type;

   function automatic logic [PT_AW-1:0] point_addr(input logic [IDX_W-1:0] idx);
      logic [IDX_EXT_W-1:0] ext;
      ext = {{(IDX_EXT_W-IDX_W){1'b0}}, idx};
      return ext[PT_AW-1:0];
   endfunction

   function automatic logic point_in_range(input logic [IDX_W-1:0] idx);
      logic [IDX_EXT_W-1:0] ext;
      ext = {{(IDX_EXT_W-IDX_W){1'b0}}, idx};
      return ext < IDX_EXT_W'(NUM_POINTS);
   endfunction

endpackage

`default_nettype wire

@@ hdl/alac_table.sv @@
// Per-point alarm state memory with post-reset clearing sweep.
`default_nettype none

module alac_table
   import alac_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [PT_AW-1:0] rd_addr,
   output      entry_type        rd_data,
   input  wire logic             wr_en,
   input  wire logic [PT_AW-1:0] wr_addr,
   input  wire entry_type        wr_data,
   output      logic             ready
);

   entry_type        mem [NUM_POINTS];
   entry_type        rd_data_ff;
   logic             clearing_ff;
   logic             clearing_in;
   logic [PT_AW-1:0] clr_addr_ff;
   logic [PT_AW-1:0] clr_addr_in;
   logic             we;
   logic [PT_AW-1:0] waddr;
   entry_type        wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == PT_AW'(NUM_POINTS - 1)) begin
            clearing_in = 1'b0;
         end
      end
      we    = clearing_ff || wr_en;
      waddr = clearing_ff ? clr_addr_ff : wr_addr;
      wdata = clearing_ff ? entry_type'('0) : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clearing_ff;

endmodule

`default_nettype wire

@@ hdl/alac_eval.sv @@
// Level classification, delay check and state update for one sample.
`default_nettype none

module alac_eval
   import alac_pkg::*;
(
   input  wire req_word_type item,
   input  wire entry_type    entry,
   output      eval_out_type result
);

   logic signed [31:0] v;
   logic signed [31:0] lo;
   logic signed [31:0] hi;
   logic signed [31:0] lolo;
   logic signed [31:0] hihi;
   logic               in_band;
   logic               changed;
   logic               delay_zero;
   logic               expired;
   logic [31:0]        elapsed;
   alarm_level_type    new_level;

   always_comb begin
      v    = $signed(item.sample_value);
      lo   = $signed(item.low_limit);
      hi   = $signed(item.high_limit);
      lolo = $signed(item.lowlow_limit);
      hihi = $signed(item.highhigh_limit);

      unique case (entry.level)
         LVL_NORMAL: in_band = (v >= lo) && (v <= hi);
         LVL_HIGH:   in_band = (v > hi) && (v <= hihi);
         LVL_LOW:    in_band = (v < lo) && (v >= lolo);
         LVL_HIHI:   in_band = v > hihi;
         LVL_LOLO:   in_band = v < lolo;
         default:    in_band = 1'b0;
      endcase

      priority if (v > hihi) begin
         new_level = LVL_HIHI;
      end else if (v < lolo) begin
         new_level = LVL_LOLO;
      end else if (v > hi) begin
         new_level = LVL_HIGH;
      end else if (v < lo) begin
         new_level = LVL_LOW;
      end else begin
         new_level = LVL_NORMAL;
      end

      changed    = item.alarm_enabled && !in_band;
      delay_zero = (item.delay_seconds == 16'd0);
      elapsed    = item.now_seconds - entry.start_time;
      expired    = elapsed > {16'd0, item.delay_seconds};

      result.entry_next = entry;
      result.fire       = 1'b0;
      result.level      = entry.level;

      if (changed) begin
         result.entry_next.level      = new_level;
         result.entry_next.start_time = item.now_seconds;
         result.level                 = new_level;
         if (new_level == LVL_HIHI || new_level == LVL_LOLO) begin
            result.entry_next.reported = 1'b1;
            result.fire                = 1'b1;
         end else if (new_level != LVL_NORMAL) begin
            result.entry_next.reported = entry.reported || delay_zero;
            result.fire                = entry.reported || delay_zero;
         end else begin
            result.entry_next.reported = 1'b1;
            result.fire                = entry.reported || delay_zero;
         end
      end else if (entry.level != LVL_NORMAL && !delay_zero && !entry.reported && expired) begin
         result.entry_next.reported   = 1'b1;
         result.entry_next.start_time = item.now_seconds;
         result.fire                  = 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ hdl/analog_limit_alarm_checker.sv @@
// Top level of the four-level analog limit alarm checker.
// Accepted samples are registered in s1; result words in the output or skid stage.
// Throughput: one sample per cycle while req_stall is low; a table
// read-modify-write with forwarding of the write-back to a back-to-back sample
// of the same point sets that rate. Reset: synchronous; afterwards all NUM_POINTS
// (1024) table entries are swept to zero with req_stall held high.
`default_nettype none

module analog_limit_alarm_checker
   import alac_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [9:0]         req_point_index,
   input  wire logic signed [31:0] req_sample_value,
   input  wire logic signed [31:0] req_previous_value,
   input  wire logic signed [31:0] req_low_limit,
   input  wire logic signed [31:0] req_high_limit,
   input  wire logic signed [31:0] req_lowlow_limit,
   input  wire logic signed [31:0] req_highhigh_limit,
   input  wire logic [15:0]        req_delay_seconds,
   input  wire logic               req_point_valid,
   input  wire logic               req_alarm_enabled,
   input  wire logic [31:0]        req_now_seconds,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic               rsp_event_valid,
   output      logic [9:0]         rsp_event_point,
   output      logic [2:0]         rsp_event_level,
   output      logic               rsp_is_return,
   output      logic               rsp_escalated,
   output      logic signed [31:0] rsp_event_value,
   output      logic signed [31:0] rsp_event_previous
);

   logic             table_ready;
   logic             accept;
   logic [PT_AW-1:0] req_addr;
   logic [PT_AW-1:0] s1_addr;
   req_word_type     req_word;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   req_word_type     s1_item_ff;

   logic             fwd_hit_ff;
   logic             fwd_hit_in;
   entry_type        fwd_data_ff;

   entry_type        rd_data;
   entry_type        cur_entry;
   eval_out_type     eval_out;
   logic             s1_fire;
   rsp_word_type     s1_word;

   logic             out_valid_ff;
   logic             out_valid_in;
   rsp_word_type     out_ff;
   rsp_word_type     out_in;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   rsp_word_type     skid_ff;
   rsp_word_type     skid_in;
   logic             out_take;

   always_comb begin
      req_word.point_index    = req_point_index;
      req_word.sample_value   = req_sample_value;
      req_word.previous_value = req_previous_value;
      req_word.low_limit      = req_low_limit;
      req_word.high_limit     = req_high_limit;
      req_word.lowlow_limit   = req_lowlow_limit;
      req_word.highhigh_limit = req_highhigh_limit;
      req_word.delay_seconds  = req_delay_seconds;
      req_word.alarm_enabled  = req_alarm_enabled;
      req_word.now_seconds    = req_now_seconds;
   end

   assign req_stall   = !table_ready || skid_valid_ff || (out_valid_ff && rsp_stall);
   assign accept      = req_valid && !req_stall;
   assign req_addr    = point_addr(req_point_index);
   assign s1_addr     = point_addr(s1_item_ff.point_index);
   assign s1_valid_in = accept && req_point_valid && point_in_range(req_point_index);
   assign fwd_hit_in  = accept && s1_valid_ff && (s1_addr == req_addr);
   assign cur_entry   = fwd_hit_ff ? fwd_data_ff : rd_data;

   alac_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_data),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr),
      .wr_data (eval_out.entry_next),
      .ready   (table_ready)
   );

   alac_eval u_eval (
      .item   (s1_item_ff),
      .entry  (cur_entry),
      .result (eval_out)
   );

   always_comb begin
      s1_fire                = s1_valid_ff && eval_out.fire;
      s1_word.event_point    = s1_item_ff.point_index;
      s1_word.event_level    = eval_out.level;
      s1_word.is_return      = (eval_out.level == LVL_NORMAL);
      s1_word.escalated      = (eval_out.level == LVL_HIHI) || (eval_out.level == LVL_LOLO);
      s1_word.event_value    = s1_item_ff.sample_value;
      s1_word.event_previous = s1_item_ff.previous_value;
   end

   // advance the output word, park a new word in the skid stage when stalled
   always_comb begin
      out_take      = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = s1_fire;
            skid_in       = s1_word;
         end else begin
            out_valid_in  = s1_fire;
            out_in        = s1_word;
         end
      end else if (s1_fire) begin
         skid_valid_in = 1'b1;
         skid_in       = s1_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_word;
      end
      fwd_data_ff <= eval_out.entry_next;
      out_ff      <= out_in;
      skid_ff     <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_valid    = 1'b1;
   assign rsp_event_point    = out_ff.event_point;
   assign rsp_event_level    = out_ff.event_level;
   assign rsp_is_return      = out_ff.is_return;
   assign rsp_escalated      = out_ff.escalated;
   assign rsp_event_value    = $signed(out_ff.event_value);
   assign rsp_event_previous = $signed(out_ff.event_previous);

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the analog limit alarm checker against a per-point table.
`timescale 1ns / 100ps

module tb;
   import alac_pkg::*;

   localparam int IDLE_PCT        = 35;
   localparam int RANDOM_WORDS    = 450;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int WATCHDOG_LIMIT  = 6000;
   localparam int SETTLE_CYCLES   = 16;

   typedef struct packed {
      logic [9:0]  point_index;
      logic [31:0] sample_value;
      logic [31:0] previous_value;
      logic [31:0] low_limit;
      logic [31:0] high_limit;
      logic [31:0] lowlow_limit;
      logic [31:0] highhigh_limit;
      logic [15:0] delay_seconds;
      logic        point_valid;
      logic        alarm_enabled;
      logic [31:0] now_seconds;
      logic        drain_first;
   } sample_word_type;

   typedef struct packed {
      logic [9:0]      point;
      alarm_level_type level;
      logic            is_return;
      logic            escalated;
      logic [31:0]     value;
      logic [31:0]     previous;
   } alarm_event_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [9:0]         req_point_index = '0;
   logic signed [31:0] req_sample_value = '0;
   logic signed [31:0] req_previous_value = '0;
   logic signed [31:0] req_low_limit = '0;
   logic signed [31:0] req_high_limit = '0;
   logic signed [31:0] req_lowlow_limit = '0;
   logic signed [31:0] req_highhigh_limit = '0;
   logic [15:0]        req_delay_seconds = '0;
   logic               req_point_valid = 1'b0;
   logic               req_alarm_enabled = 1'b0;
   logic [31:0]        req_now_seconds = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_event_valid;
   logic [9:0]         rsp_event_point;
   logic [2:0]         rsp_event_level;
   logic               rsp_is_return;
   logic               rsp_escalated;
   logic signed [31:0] rsp_event_value;
   logic signed [31:0] rsp_event_previous;

   alarm_level_type point_level [NUM_POINTS];
   logic            point_reported [NUM_POINTS];
   logic [31:0]     point_since [NUM_POINTS];

   sample_word_type sample_backlog [$];
   alarm_event_type due_events [$];
   sample_word_type driven_word;

   int   offered_count = 0;
   int   taken_count = 0;
   int   error_count = 0;
   int   starved_cycles = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   logic quiet_phase;

   assign quiet_phase = (taken_count >= 330) && (taken_count < 430);

   analog_limit_alarm_checker i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_point_index    (req_point_index),
      .req_sample_value   (req_sample_value),
      .req_previous_value (req_previous_value),
      .req_low_limit      (req_low_limit),
      .req_high_limit     (req_high_limit),
      .req_lowlow_limit   (req_lowlow_limit),
      .req_highhigh_limit (req_highhigh_limit),
      .req_delay_seconds  (req_delay_seconds),
      .req_point_valid    (req_point_valid),
      .req_alarm_enabled  (req_alarm_enabled),
      .req_now_seconds    (req_now_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_event_point    (rsp_event_point),
      .rsp_event_level    (rsp_event_level),
      .rsp_is_return      (rsp_is_return),
      .rsp_escalated      (rsp_escalated),
      .rsp_event_value    (rsp_event_value),
      .rsp_event_previous (rsp_event_previous)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_alarm_event(input sample_word_type w);
      alarm_level_type    lvl;
      logic               keep;
      logic               fire;
      logic [31:0]        elapsed;
      logic signed [31:0] v;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic signed [31:0] lolo;
      logic signed [31:0] hihi;
      alarm_event_type    ev;
      if (!w.point_valid || w.point_index >= NUM_POINTS) return;
      v    = w.sample_value;
      lo   = w.low_limit;
      hi   = w.high_limit;
      lolo = w.lowlow_limit;
      hihi = w.highhigh_limit;
      lvl  = point_level[w.point_index];
      fire = 1'b0;
      case (lvl)
         LVL_NORMAL: keep = (v >= lo) && (v <= hi);
         LVL_HIGH:   keep = (v > hi) && (v <= hihi);
         LVL_LOW:    keep = (v < lo) && (v >= lolo);
         LVL_HIHI:   keep = v > hihi;
         LVL_LOLO:   keep = v < lolo;
         default:    keep = 1'b0;
      endcase
      elapsed = w.now_seconds - point_since[w.point_index];
      if (w.alarm_enabled && !keep) begin
         if (v > hihi) lvl = LVL_HIHI;
         else if (v < lolo) lvl = LVL_LOLO;
         else if (v > hi) lvl = LVL_HIGH;
         else if (v < lo) lvl = LVL_LOW;
         else lvl = LVL_NORMAL;
         point_level[w.point_index] = lvl;
         point_since[w.point_index] = w.now_seconds;
         if (lvl == LVL_HIHI || lvl == LVL_LOLO) begin
            point_reported[w.point_index] = 1'b1;
            fire = 1'b1;
         end else if (lvl != LVL_NORMAL) begin
            if (point_reported[w.point_index] || w.delay_seconds == 16'd0) begin
               point_reported[w.point_index] = 1'b1;
               fire = 1'b1;
            end
         end else begin
            fire = point_reported[w.point_index] || w.delay_seconds == 16'd0;
            point_reported[w.point_index] = 1'b1;
         end
      end else if (lvl != LVL_NORMAL && w.delay_seconds != 16'd0
                   && !point_reported[w.point_index]
                   && elapsed > {16'd0, w.delay_seconds}) begin
         point_reported[w.point_index] = 1'b1;
         point_since[w.point_index] = w.now_seconds;
         fire = 1'b1;
      end
      if (!fire) return;
      ev.point     = w.point_index;
      ev.level     = lvl;
      ev.is_return = lvl == LVL_NORMAL;
      ev.escalated = lvl == LVL_HIHI || lvl == LVL_LOLO;
      ev.value     = w.sample_value;
      ev.previous  = w.previous_value;
      due_events.push_back(ev);
   endfunction

   function automatic sample_word_type make_word(input int pt, input int val, input int lolo,
                                                 input int lo, input int hi, input int hihi,
                                                 input int dly, input logic en,
                                                 input logic [31:0] t);
      sample_word_type w;
      w.point_index    = 10'(pt);
      w.sample_value   = val;
      w.previous_value = $urandom;
      w.low_limit      = lo;
      w.high_limit     = hi;
      w.lowlow_limit   = lolo;
      w.highhigh_limit = hihi;
      w.delay_seconds  = 16'(dly);
      w.point_valid    = 1'b1;
      w.alarm_enabled  = en;
      w.now_seconds    = t;
      w.drain_first    = 1'b0;
      return w;
   endfunction

   initial begin : stimulus
      sample_word_type w;
      logic [31:0]     wall_time;
      logic [9:0]      window_base;
      int              prof_lo [8];
      int              prof_hi [8];
      int              prof_lolo [8];
      int              prof_hihi [8];
      int              prof_delay [8];
      int              made;
      int              pass_cnt;
      int              slot;
      int              roll;
      int              v;
      int              centre;
      int              gap_in;
      int              gap_out;
      int              pick;

      for (int i = 0; i < NUM_POINTS; i++) begin
         point_level[i]    = LVL_NORMAL;
         point_reported[i] = 1'b0;
         point_since[i]    = '0;
      end

      // level walk with zero delay
      sample_backlog.push_back(make_word(0, 0, -200, -100, 100, 200, 0, 1'b1, 5));
      sample_backlog.push_back(make_word(0, 150, -200, -100, 100, 200, 0, 1'b1, 6));
      sample_backlog.push_back(make_word(0, 250, -200, -100, 100, 200, 0, 1'b1, 7));
      sample_backlog.push_back(make_word(0, 0, -200, -100, 100, 200, 0, 1'b1, 8));
      // delayed high alarm, then low, low-low, return
      sample_backlog.push_back(make_word(1, 150, -200, -100, 100, 200, 3, 1'b1, 10));
      sample_backlog.push_back(make_word(1, 150, -200, -100, 100, 200, 3, 1'b1, 12));
      sample_backlog.push_back(make_word(1, 150, -200, -100, 100, 200, 3, 1'b1, 14));
      sample_backlog.push_back(make_word(1, -150, -200, -100, 100, 200, 3, 1'b1, 15));
      sample_backlog.push_back(make_word(1, -250, -200, -100, 100, 200, 3, 1'b1, 16));
      sample_backlog.push_back(make_word(1, 0, -200, -100, 100, 200, 3, 1'b1, 17));
      // silent return before the delay ran out
      sample_backlog.push_back(make_word(2, -150, -200, -100, 100, 200, 5, 1'b1, 20));
      sample_backlog.push_back(make_word(2, 0, -200, -100, 100, 200, 5, 1'b1, 21));
      sample_backlog.push_back(make_word(2, -150, -200, -100, 100, 200, 5, 1'b1, 30));
      // invalid point, then checking disabled
      w = make_word(3, 1000, -200, -100, 100, 200, 0, 1'b1, 31);
      w.point_valid = 1'b0;
      sample_backlog.push_back(w);
      sample_backlog.push_back(make_word(3, 1000, -200, -100, 100, 200, 0, 1'b0, 32));
      // delay expiry with checking disabled
      sample_backlog.push_back(make_word(6, 150, -200, -100, 100, 200, 1, 1'b1, 100));
      sample_backlog.push_back(make_word(6, 0, -200, -100, 100, 200, 1, 1'b0, 105));
      // elapsed time across the wrap
      sample_backlog.push_back(make_word(4, 150, -200, -100, 100, 200, 2, 1'b1, 32'hFFFF_FFFF));
      sample_backlog.push_back(make_word(4, 150, -200, -100, 100, 200, 2, 1'b1, 2));
      // longest delay
      sample_backlog.push_back(make_word(5, 150, -200, -100, 100, 200, 65535, 1'b1, 0));
      sample_backlog.push_back(make_word(5, 150, -200, -100, 100, 200, 65535, 1'b1, 65535));
      sample_backlog.push_back(make_word(5, 150, -200, -100, 100, 200, 65535, 1'b1, 65536));
      // full-scale values at the last point
      sample_backlog.push_back(make_word(1023, 32'sh8000_0000, 32'sh8000_0001, -100, 100,
                                         32'sh7FFF_FFFE, 0, 1'b1, 40));
      sample_backlog.push_back(make_word(1023, 32'sh7FFF_FFFF, 32'sh8000_0001, -100, 100,
                                         32'sh7FFF_FFFE, 0, 1'b1, 41));
      sample_backlog.push_back(make_word(1023, 32'sh7FFF_FFFF, 32'sh8000_0000, -100,
                                         32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 0, 1'b1, 42));

      wall_time   = 32'd1000;
      window_base = 10'd16;
      made        = 0;
      pass_cnt    = 0;
      slot        = 0;
      while (made < RANDOM_WORDS) begin
         if (pass_cnt % 40 == 0) begin
            window_base = window_base + 10'd8;
            for (int k = 0; k < 8; k++) begin
               centre = $urandom_range(0, 536870912) - 268435456;
               gap_in = $urandom_range(2, 262144);
               gap_out = $urandom_range(2, 262144);
               prof_lo[k] = centre - gap_in;
               prof_hi[k] = centre + gap_in;
               prof_lolo[k] = prof_lo[k] - gap_out;
               prof_hihi[k] = prof_hi[k] + gap_out;
               pick = $urandom_range(0, 9);
               if (pick < 3) prof_delay[k] = 0;
               else if (pick < 8) prof_delay[k] = $urandom_range(1, 4);
               else if (pick == 8) prof_delay[k] = 65535;
               else prof_delay[k] = $urandom_range(0, 65535);
            end
         end
         if (pass_cnt == 100) wall_time = 32'hFFFF_FFF0;
         else if ($urandom_range(0, 99) < 3) wall_time = $urandom;
         else wall_time = wall_time + $urandom_range(0, 3);
         if ($urandom_range(0, 4) != 0) slot = $urandom_range(0, 7);
         case ($urandom_range(0, 5))
            0: v = prof_lo[slot] + $urandom_range(0, prof_hi[slot] - prof_lo[slot]);
            1: v = prof_hi[slot] + 1 + $urandom_range(0, prof_hihi[slot] - prof_hi[slot] - 1);
            2: v = prof_lolo[slot] + $urandom_range(0, prof_lo[slot] - prof_lolo[slot] - 1);
            3: v = prof_hihi[slot] + 1 + $urandom_range(0, 1048576);
            4: v = prof_lolo[slot] - 1 - $urandom_range(0, 1048576);
            default: begin
               pick = $urandom_range(0, 7);
               case (pick >> 1)
                  0: v = prof_lo[slot];
                  1: v = prof_hi[slot];
                  2: v = prof_lolo[slot];
                  default: v = prof_hihi[slot];
               endcase
               v = (pick[0] == (pick < 2 || (pick >= 4 && pick < 6))) ? v : v;
               if (pick[0]) v = (pick < 2 || (pick >= 4 && pick < 6)) ? v - 1 : v + 1;
            end
         endcase
         w = make_word(window_base + slot, v, prof_lolo[slot], prof_lo[slot], prof_hi[slot],
                       prof_hihi[slot], prof_delay[slot], 1'b1, wall_time);
         roll = $urandom_range(0, 99);
         if (roll >= 95) begin
            w.alarm_enabled = 1'b0;
         end else if (roll >= 90) begin
            w.point_valid = 1'b0;
         end else if (roll >= 80) begin
            w.point_index    = 10'($urandom);
            w.sample_value   = $urandom;
            w.low_limit      = $urandom;
            w.high_limit     = $urandom;
            w.lowlow_limit   = $urandom;
            w.highhigh_limit = $urandom;
            w.delay_seconds  = 16'($urandom);
            w.alarm_enabled  = 1'($urandom);
            w.now_seconds    = $urandom;
         end
         w.drain_first = made == 250;
         sample_backlog.push_back(w);
         made++;
         pass_cnt++;
      end

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (sample_backlog.size() != 0 || taken_count != offered_count
             || due_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && due_events.size() == 0) begin
         $display("** analog_limit_alarm_checker: PASSED **");
      end else begin
         $display("** analog_limit_alarm_checker: FAILED **");
      end
      $finish;
   end

   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && taken_count != offered_count) begin
         // hold the stalled word
      end else if (sample_backlog.size() == 0
                   || (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT)
                   || (sample_backlog[0].drain_first && due_events.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         driven_word = sample_backlog.pop_front();
         req_point_index    <= driven_word.point_index;
         req_sample_value   <= driven_word.sample_value;
         req_previous_value <= driven_word.previous_value;
         req_low_limit      <= driven_word.low_limit;
         req_high_limit     <= driven_word.high_limit;
         req_lowlow_limit   <= driven_word.lowlow_limit;
         req_highhigh_limit <= driven_word.highhigh_limit;
         req_delay_seconds  <= driven_word.delay_seconds;
         req_point_valid    <= driven_word.point_valid;
         req_alarm_enabled  <= driven_word.alarm_enabled;
         req_now_seconds    <= driven_word.now_seconds;
         req_valid          <= 1'b1;
         offered_count      <= offered_count + 1;
      end
   end

   always @(negedge clock) begin : receiver
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && taken_count >= 120) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_phase && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin : monitor
      alarm_event_type exp_ev;
      if (!reset && req_valid && !req_stall) begin
         predict_alarm_event(driven_word);
         taken_count <= taken_count + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_events.size() == 0) begin
            error_count++;
            $error("unexpected event word: point %0d level %0d", rsp_event_point,
                   rsp_event_level);
         end else begin
            exp_ev = due_events.pop_front();
            if (rsp_event_valid !== 1'b1) begin
               error_count++;
               $error("event_valid: expected 1, got %b", rsp_event_valid);
            end
            if (rsp_event_point !== exp_ev.point) begin
               error_count++;
               $error("event_point: expected %0d, got %0d", exp_ev.point, rsp_event_point);
            end
            if (rsp_event_level !== exp_ev.level) begin
               error_count++;
               $error("event_level: expected %0d, got %0d", exp_ev.level, rsp_event_level);
            end
            if (rsp_is_return !== exp_ev.is_return) begin
               error_count++;
               $error("is_return: expected %b, got %b", exp_ev.is_return, rsp_is_return);
            end
            if (rsp_escalated !== exp_ev.escalated) begin
               error_count++;
               $error("escalated: expected %b, got %b", exp_ev.escalated, rsp_escalated);
            end
            if (rsp_event_value !== exp_ev.value) begin
               error_count++;
               $error("event_value: expected %h, got %h", exp_ev.value, rsp_event_value);
            end
            if (rsp_event_previous !== exp_ev.previous) begin
               error_count++;
               $error("event_previous: expected %h, got %h", exp_ev.previous,
                      rsp_event_previous);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         starved_cycles <= 0;
      end else if (starved_cycles >= WATCHDOG_LIMIT) begin
         $display("** analog_limit_alarm_checker: FAILED **");
         $finish;
      end else begin
         starved_cycles <= starved_cycles + 1;
      end
   end

endmodule
